// File: rtl/bzf_pkg.sv
// bzf_pkg: shared types, constants and helpers of the bezier curve flattener
// used by every module of the flattener; depends on nothing

package bzf_pkg;

    localparam int COORD_W = 32;
    localparam int TOL_W   = 31;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd65536;

    // one curve segment as it sits in the queue
    typedef struct packed {
        logic                      cubic;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic signed [COORD_W-1:0] x3;
        logic signed [COORD_W-1:0] y3;
    } bzf_item_t;

    // request to the flatness tester: point p against chord s..e
    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
    } bzf_flat_req_t;

    typedef struct packed {
        logic done;
        logic ok;
    } bzf_flat_rsp_t;

    // floor((a + b) / 2) on the 33-bit sum
    function automatic logic signed [COORD_W-1:0] bzf_mid(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        begin
            s = $signed({a[COORD_W-1], a}) + $signed({b[COORD_W-1], b});
            bzf_mid = s[COORD_W:1];
        end
    endfunction

endpackage

// File: rtl/bezier_curve_flattener.sv
// bezier_curve_flattener: top level, tolerance register, input queue and engine
// depends on bzf_pkg, bzf_front, bzf_back
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+---------------------------
//  input   | kind, start_x .. end_y                    | start, busy (taken: start & !busy)
//  config  | cfg_data (flatness tolerance, Q15.16)     | cfg_valid, cfg_ready
//  result  | point_x, point_y, last_point              | result_valid, one-cycle strobe
//
// a two-word queue takes segments while the engine works; busy rises when it is full.
// the engine visits up to 2^(MAX_DEPTH+1)-1 pieces; each flatness test runs 12 products
// (3 on a degenerate chord) through one shared 33x33 multiplier.
// results come out one piece at a time, never back to back, and cannot be stalled.
// reset clears the queue, the engine and the tolerance to 1.0.

module bezier_curve_flattener #(
    parameter int MAX_DEPTH = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] ctrl1_x,
    input  logic signed [31:0] ctrl1_y,
    input  logic signed [31:0] ctrl2_x,
    input  logic signed [31:0] ctrl2_y,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic               last_point,
    output logic               result_valid
);
    import bzf_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    bzf_item_t        q_item;
    logic             q_valid, q_pop;

    assign cfg_ready = 1'b1;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_valid && cfg_ready)
            tol_reg <= cfg_data;
    end

    bzf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .kind    (kind),
        .start_x (start_x),
        .start_y (start_y),
        .ctrl1_x (ctrl1_x),
        .ctrl1_y (ctrl1_y),
        .ctrl2_x (ctrl2_x),
        .ctrl2_y (ctrl2_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    bzf_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tol          (tol_reg),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_point   (last_point),
        .result_valid (result_valid)
    );

endmodule

// File: rtl/bzf_front.sv
// bzf_front: accepts curve segments and queues them for the subdivision engine
// depends on bzf_pkg

module bzf_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       kind,
    input  logic signed [31:0]         start_x,
    input  logic signed [31:0]         start_y,
    input  logic signed [31:0]         ctrl1_x,
    input  logic signed [31:0]         ctrl1_y,
    input  logic signed [31:0]         ctrl2_x,
    input  logic signed [31:0]         ctrl2_y,
    input  logic signed [31:0]         end_x,
    input  logic signed [31:0]         end_y,
    output bzf_pkg::bzf_item_t         q_item,
    output logic                       q_valid,
    input  logic                       q_pop
);
    import bzf_pkg::*;

    bzf_item_t  fifo_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    bzf_item_t  item_in;

    // classify: quadratic segments carry no second control point
    always_comb
    begin
        item_in.cubic = kind;
        item_in.x0    = start_x;
        item_in.y0    = start_y;
        item_in.x1    = ctrl1_x;
        item_in.y1    = ctrl1_y;
        item_in.x2    = kind ? ctrl2_x : '0;
        item_in.y2    = kind ? ctrl2_y : '0;
        item_in.x3    = end_x;
        item_in.y3    = end_y;
    end

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = fifo_mem[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: rtl/bzf_flat.sv
// bzf_flat: exact squared point-to-chord distance test on one shared multiplier
// depends on bzf_pkg

module bzf_flat (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [30:0]             tol,
    input  bzf_pkg::bzf_flat_req_t  req,
    output bzf_pkg::bzf_flat_rsp_t  rsp
);
    import bzf_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC, F_CMP} fstate_t;
    typedef enum logic [3:0] {
        ST_MA, ST_MB, ST_LL, ST_LM, ST_LH, ST_TT, ST_DX, ST_DY,
        ST_RLL, ST_RLH, ST_RHL, ST_RHH, ST_QX, ST_QY
    } step_t;

    fstate_t state_reg, state_next;
    step_t   step_reg, step_next;
    logic    done_reg, ok_reg;

    logic [32:0]  mdx_reg, mdy_reg, mqx_reg, mqy_reg;
    logic         sdiff_reg, deg_reg;
    logic [65:0]  prod_reg;
    logic [65:0]  ma_reg;
    logic [64:0]  l_reg;
    logic [61:0]  tt_reg;
    logic [64:0]  dd_reg;
    logic [129:0] lhs_reg, rhs_reg;

    logic signed [32:0] dx, dy, qx, qy;
    logic [32:0]  op_a, op_b;
    logic [129:0] prod_w;
    logic [65:0]  lsum;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    // differences to the chord start
    always_comb
    begin
        dx = $signed({req.ex[31], req.ex}) - $signed({req.sx[31], req.sx});
        dy = $signed({req.ey[31], req.ey}) - $signed({req.sy[31], req.sy});
        qx = $signed({req.px[31], req.px}) - $signed({req.sx[31], req.sx});
        qy = $signed({req.py[31], req.py}) - $signed({req.sy[31], req.sy});
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        unique case (step_reg)
            ST_MA:   begin op_a = mdy_reg;              op_b = mqx_reg;              end
            ST_MB:   begin op_a = mdx_reg;              op_b = mqy_reg;              end
            ST_LL:   begin op_a = l_reg[32:0];          op_b = l_reg[32:0];          end
            ST_LM:   begin op_a = l_reg[32:0];          op_b = {1'b0, l_reg[64:33]}; end
            ST_LH:   begin op_a = {1'b0, l_reg[64:33]}; op_b = {1'b0, l_reg[64:33]}; end
            ST_TT:   begin op_a = {2'b0, tol};          op_b = {2'b0, tol};          end
            ST_DX:   begin op_a = mdx_reg;              op_b = mdx_reg;              end
            ST_DY:   begin op_a = mdy_reg;              op_b = mdy_reg;              end
            ST_RLL:  begin op_a = tt_reg[32:0];         op_b = dd_reg[32:0];         end
            ST_RLH:  begin op_a = tt_reg[32:0];         op_b = {1'b0, dd_reg[64:33]}; end
            ST_RHL:  begin op_a = {4'b0, tt_reg[61:33]}; op_b = dd_reg[32:0];        end
            ST_RHH:  begin op_a = {4'b0, tt_reg[61:33]}; op_b = {1'b0, dd_reg[64:33]}; end
            ST_QX:   begin op_a = mqx_reg;              op_b = mqx_reg;              end
            ST_QY:   begin op_a = mqy_reg;              op_b = mqy_reg;              end
            default: begin op_a = '0;                   op_b = '0;                   end
        endcase
    end

    assign prod_w = {64'd0, prod_reg};
    assign lsum   = ma_reg + prod_reg;

    // step sequence
    always_comb
    begin
        unique case (step_reg)
            ST_MA:   step_next = ST_MB;
            ST_MB:   step_next = ST_LL;
            ST_LL:   step_next = ST_LM;
            ST_LM:   step_next = ST_LH;
            ST_LH:   step_next = ST_TT;
            ST_TT:   step_next = deg_reg ? ST_QX : ST_DX;
            ST_DX:   step_next = ST_DY;
            ST_DY:   step_next = ST_RLL;
            ST_RLL:  step_next = ST_RLH;
            ST_RLH:  step_next = ST_RHL;
            ST_RHL:  step_next = ST_RHH;
            ST_QX:   step_next = ST_QY;
            default: step_next = ST_MA;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (req.start) state_next = F_MUL;
            F_MUL:   state_next = F_ACC;
            F_ACC:   state_next = (step_reg == ST_RHH || step_reg == ST_QY) ? F_CMP : F_MUL;
            F_CMP:   state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // state and response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= ST_MA;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == F_CMP);
            if (state_reg == F_CMP)
            begin
                ok_reg <= (lhs_reg <= rhs_reg);
            end
            if (state_reg == F_IDLE && req.start)
            begin
                step_reg <= (dx == 33'sd0 && dy == 33'sd0) ? ST_TT : ST_MA;
            end
            else if (state_reg == F_ACC)
            begin
                step_reg <= step_next;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ok   = ok_reg;

    // datapath: operands, product and accumulators
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && req.start)
        begin
            mdx_reg   <= mag33(dx);
            mdy_reg   <= mag33(dy);
            mqx_reg   <= mag33(qx);
            mqy_reg   <= mag33(qy);
            sdiff_reg <= (dy[32] ^ qx[32]) ^ (dx[32] ^ qy[32]);
            deg_reg   <= (dx == 33'sd0 && dy == 33'sd0);
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= op_a * op_b;
        end
        if (state_reg == F_ACC)
        begin
            unique case (step_reg)
                ST_MA:  ma_reg  <= prod_reg;
                ST_MB:  l_reg   <= sdiff_reg ? lsum[64:0]
                                   : (ma_reg > prod_reg ? 65'(ma_reg - prod_reg)
                                                        : 65'(prod_reg - ma_reg));
                ST_LL:  lhs_reg <= prod_w;
                ST_LM:  lhs_reg <= lhs_reg + (prod_w << 34);
                ST_LH:  lhs_reg <= lhs_reg + (prod_w << 66);
                ST_TT:  tt_reg  <= prod_reg[61:0];
                ST_DX:  dd_reg  <= prod_reg[64:0];
                ST_DY:  dd_reg  <= dd_reg + prod_reg[64:0];
                ST_RLL: rhs_reg <= prod_w;
                ST_RLH: rhs_reg <= rhs_reg + (prod_w << 33);
                ST_RHL: rhs_reg <= rhs_reg + (prod_w << 33);
                ST_RHH: rhs_reg <= rhs_reg + (prod_w << 66);
                ST_QX:  lhs_reg <= prod_w;
                ST_QY:
                begin
                    lhs_reg <= lhs_reg + prod_w;
                    rhs_reg <= {68'd0, tt_reg};
                end
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/bzf_back.sv
// bzf_back: depth-first midpoint subdivision with a stack of right halves
// depends on bzf_pkg and bzf_flat

module bzf_back #(
    parameter int MAX_DEPTH = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [30:0]          tol,
    input  bzf_pkg::bzf_item_t   q_item,
    input  logic                 q_valid,
    output logic                 q_pop,
    output logic signed [31:0]   point_x,
    output logic signed [31:0]   point_y,
    output logic                 last_point,
    output logic                 result_valid
);
    import bzf_pkg::*;

    localparam int LVL_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [2:0] {
        B_IDLE, B_TEST1, B_WAIT1, B_TEST2, B_WAIT2, B_POP
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [LVL_W-1:0] lvl_reg, top_reg, top_dec;
    logic             cubic_reg;
    logic signed [31:0] cx_reg [4];
    logic signed [31:0] cy_reg [4];
    logic signed [31:0] lx [4], ly [4], rx [4], ry [4];
    logic signed [31:0] ax, ay, bx, by, ccx, ccy, lmx, lmy, rmx, rmy, sx, sy;

    logic signed [31:0] stk_x   [MAX_DEPTH][4];
    logic signed [31:0] stk_y   [MAX_DEPTH][4];
    logic [LVL_W-1:0]   stk_lvl [MAX_DEPTH];

    logic          at_limit, do_accept, do_split;
    logic          pt_valid_reg, pt_last_reg;
    logic signed [31:0] pt_x_reg, pt_y_reg;
    bzf_flat_req_t freq;
    bzf_flat_rsp_t frsp;

    assign at_limit = (lvl_reg >= LVL_W'(MAX_DEPTH));
    assign top_dec  = top_reg - 1'b1;
    assign q_pop    = (state_reg == B_IDLE) && q_valid;

    // flatness test request, control point chosen by the phase
    always_comb
    begin
        freq.start = ((state_reg == B_TEST1) || (state_reg == B_TEST2)) && !at_limit;
        freq.px    = (state_reg == B_TEST2) ? cx_reg[2] : cx_reg[1];
        freq.py    = (state_reg == B_TEST2) ? cy_reg[2] : cy_reg[1];
        freq.sx    = cx_reg[0];
        freq.sy    = cy_reg[0];
        freq.ex    = cx_reg[3];
        freq.ey    = cy_reg[3];
    end

    bzf_flat u_flat (
        .clk   (clk),
        .rst_n (rst_n),
        .tol   (tol),
        .req   (freq),
        .rsp   (frsp)
    );

    // de casteljau split at t = 1/2
    always_comb
    begin
        ax  = bzf_mid(cx_reg[0], cx_reg[1]);
        ay  = bzf_mid(cy_reg[0], cy_reg[1]);
        bx  = bzf_mid(cx_reg[1], cx_reg[2]);
        by  = bzf_mid(cy_reg[1], cy_reg[2]);
        ccx = cubic_reg ? bzf_mid(cx_reg[2], cx_reg[3]) : bzf_mid(cx_reg[1], cx_reg[3]);
        ccy = cubic_reg ? bzf_mid(cy_reg[2], cy_reg[3]) : bzf_mid(cy_reg[1], cy_reg[3]);
        lmx = bzf_mid(ax, bx);
        lmy = bzf_mid(ay, by);
        rmx = bzf_mid(bx, ccx);
        rmy = bzf_mid(by, ccy);
        sx  = cubic_reg ? bzf_mid(lmx, rmx) : bzf_mid(ax, ccx);
        sy  = cubic_reg ? bzf_mid(lmy, rmy) : bzf_mid(ay, ccy);
        lx[0] = cx_reg[0];                 ly[0] = cy_reg[0];
        lx[1] = ax;                        ly[1] = ay;
        lx[2] = cubic_reg ? lmx : '0;      ly[2] = cubic_reg ? lmy : '0;
        lx[3] = sx;                        ly[3] = sy;
        rx[0] = sx;                        ry[0] = sy;
        rx[1] = cubic_reg ? rmx : ccx;     ry[1] = cubic_reg ? rmy : ccy;
        rx[2] = cubic_reg ? ccx : '0;      ry[2] = cubic_reg ? ccy : '0;
        rx[3] = cx_reg[3];                 ry[3] = cy_reg[3];
    end

    // decide: emit the piece or split it
    always_comb
    begin
        do_accept = 1'b0;
        do_split  = 1'b0;
        unique case (state_reg)
            B_TEST1: do_accept = at_limit;
            B_WAIT1:
            begin
                do_split  = frsp.done && !frsp.ok;
                do_accept = frsp.done && frsp.ok && !cubic_reg;
            end
            B_WAIT2:
            begin
                do_split  = frsp.done && !frsp.ok;
                do_accept = frsp.done && frsp.ok;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (q_valid) state_next = B_TEST1;
            B_TEST1: state_next = at_limit ? ((top_reg == '0) ? B_IDLE : B_POP) : B_WAIT1;
            B_WAIT1:
            begin
                if (do_split)
                    state_next = B_TEST1;
                else if (do_accept)
                    state_next = (top_reg == '0) ? B_IDLE : B_POP;
                else if (frsp.done)
                    state_next = B_TEST2;
            end
            B_TEST2: state_next = B_WAIT2;
            B_WAIT2:
            begin
                if (do_split)
                    state_next = B_TEST1;
                else if (do_accept)
                    state_next = (top_reg == '0) ? B_IDLE : B_POP;
            end
            B_POP:   state_next = B_TEST1;
            default: state_next = B_IDLE;
        endcase
    end

    // control state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            top_reg      <= '0;
            lvl_reg      <= '0;
            pt_valid_reg <= 1'b0;
            pt_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pt_valid_reg <= do_accept;
            pt_last_reg  <= do_accept && (top_reg == '0);
            if (q_pop)
            begin
                top_reg <= '0;
                lvl_reg <= '0;
            end
            else if (do_split)
            begin
                top_reg <= top_reg + 1'b1;
                lvl_reg <= lvl_reg + 1'b1;
            end
            else if (state_reg == B_POP)
            begin
                top_reg <= top_dec;
                lvl_reg <= stk_lvl[top_dec[IDX_W-1:0]];
            end
        end
    end

    // working piece, stack and result payload
    always_ff @(posedge clk)
    begin
        if (do_accept)
        begin
            pt_x_reg <= cx_reg[3];
            pt_y_reg <= cy_reg[3];
        end
        if (q_pop)
        begin
            cubic_reg <= q_item.cubic;
            cx_reg[0] <= q_item.x0;  cy_reg[0] <= q_item.y0;
            cx_reg[1] <= q_item.x1;  cy_reg[1] <= q_item.y1;
            cx_reg[2] <= q_item.x2;  cy_reg[2] <= q_item.y2;
            cx_reg[3] <= q_item.x3;  cy_reg[3] <= q_item.y3;
        end
        else if (do_split)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cx_reg[i] <= lx[i];
                cy_reg[i] <= ly[i];
                stk_x[top_reg[IDX_W-1:0]][i] <= rx[i];
                stk_y[top_reg[IDX_W-1:0]][i] <= ry[i];
            end
            stk_lvl[top_reg[IDX_W-1:0]] <= lvl_reg + 1'b1;
        end
        else if (state_reg == B_POP)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cx_reg[i] <= stk_x[top_dec[IDX_W-1:0]][i];
                cy_reg[i] <= stk_y[top_dec[IDX_W-1:0]][i];
            end
        end
    end

    assign result_valid = pt_valid_reg;
    assign last_point   = pt_last_reg;
    assign point_x      = pt_x_reg;
    assign point_y      = pt_y_reg;

endmodule

// File: rtl/bzf_checker.sv
// bzf_checker: port-level checks on the flattener, bound to the top level
// depends on bezier_curve_flattener ports only

module bzf_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic last_point
);

    // the last flag only rides on a result
    a_last_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        last_point |-> result_valid)
        else $error("last_point without result_valid");

    // results are never back to back
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results in adjacent cycles");

    // the queue only fills on an accepted segment
    a_busy_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> !busy)
        else $error("busy rose without a segment");

endmodule

bind bezier_curve_flattener bzf_checker u_bzf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .last_point   (last_point)
);
